### hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

### hw/rtl/frm_pkg.sv
`default_nettype none
package frm_pkg;

  typedef struct packed {
    logic [1:0]  action;
    logic        header_valid;
    logic [7:0]  record_seq;
    logic        size_matches;
    logic        counters_valid;
    logic [31:0] hot_total;
    logic [31:0] cold_total;
  } item_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  outcome;
    logic [5:0]  page_index;
    logic [7:0]  seq_out;
    logic [31:0] hot_out;
    logic [31:0] cold_out;
    logic        last;
  } result_t;

  localparam logic [1:0] ACT_BEGIN  = 2'd0;
  localparam logic [1:0] ACT_HEADER = 2'd1;
  localparam logic [1:0] ACT_WRITE  = 2'd2;

  localparam logic [1:0] CMD_STATUS       = 2'd0;
  localparam logic [1:0] CMD_ERASE_REGION = 2'd1;
  localparam logic [1:0] CMD_ERASE_SECTOR = 2'd2;
  localparam logic [1:0] CMD_WRITE_PAGE   = 2'd3;

  localparam logic [2:0] OUT_CONTINUE    = 3'd0;
  localparam logic [2:0] OUT_ADOPTED     = 3'd1;
  localparam logic [2:0] OUT_REINIT_ZERO = 3'd2;
  localparam logic [2:0] OUT_REINIT_KEPT = 3'd3;
  localparam logic [2:0] OUT_WRITTEN     = 3'd4;
  localparam logic [2:0] OUT_IGNORED     = 3'd5;

  typedef enum logic [1:0] {
    JOB_STATUS,
    JOB_REINIT,
    JOB_WRITE,
    JOB_WRITE_ERASE
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [2:0]  outcome;
    logic [5:0]  page;
    logic [7:0]  seq;
    logic [31:0] hot;
    logic [31:0] cold;
  } job_t;

  localparam int QUEUE_DEPTH = 2;

endpackage
`default_nettype wire

### hw/rtl/frm_front.sv
`default_nettype none
module frm_front #(
  parameter int NUM_PAGES        = 64,
  parameter int PAGES_PER_SECTOR = 16,
  parameter int SEQ_BITS         = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_ready,
  input  wire frm_pkg::item_t item,
  input  wire logic          q_full,
  output logic               q_push,
  output frm_pkg::job_t      q_job
);
  import frm_pkg::*;

  localparam int PW  = $clog2(NUM_PAGES);
  localparam int SPW = $clog2(NUM_PAGES + 1);
  localparam int OW  = (PAGES_PER_SECTOR > 1) ? $clog2(PAGES_PER_SECTOR) : 1;
  localparam logic [SPW-1:0] END_POS   = SPW'(NUM_PAGES);
  localparam logic [PW-1:0]  LAST_PAGE = PW'(NUM_PAGES - 1);
  localparam logic [OW-1:0]  LAST_OFF  = OW'(PAGES_PER_SECTOR - 1);

  logic                scanning, scanning_next;
  logic [SPW-1:0]      scan_position, scan_position_next;
  logic [OW-1:0]       scan_off, scan_off_next;
  logic [SEQ_BITS-1:0] best_seq, best_seq_next;
  logic                best_size_ok, best_size_ok_next;
  logic                best_counters_ok, best_counters_ok_next;
  logic [31:0]         best_hot, best_hot_next;
  logic [31:0]         best_cold, best_cold_next;
  logic [PW-1:0]       current_page, current_page_next;
  logic [OW-1:0]       cur_off, cur_off_next;
  logic [SEQ_BITS-1:0] current_seq, current_seq_next;

  logic [SEQ_BITS+7:0] rseq_ext;
  logic [SEQ_BITS-1:0] rseq;
  logic [SPW-1:0]      pos_inc;
  logic [OW-1:0]       off_inc;
  logic                take;
  logic                finish;
  logic [SPW-1:0]      adopt_pos;
  logic [PW-1:0]       adopt_page;
  logic [PW+5:0]       page_ext;
  logic [SEQ_BITS+7:0] seq_ext;
  logic [PW-1:0]       wr_page;
  logic [OW-1:0]       wr_off;
  job_t                job;

  assign item_ready = !q_full;
  assign q_push     = item_valid && !q_full;
  assign q_job      = job;

  assign rseq_ext = {{SEQ_BITS{1'b0}}, item.record_seq};
  assign rseq     = rseq_ext[SEQ_BITS-1:0];
  assign pos_inc  = scan_position + 1'b1;
  assign off_inc  = (scan_off == LAST_OFF) ? '0 : scan_off + 1'b1;
  assign wr_page  = (current_page == LAST_PAGE) ? '0 : current_page + 1'b1;
  assign wr_off   = ((current_page == LAST_PAGE) || (cur_off == LAST_OFF)) ? '0 :
                    cur_off + 1'b1;

  always_comb begin
    scanning_next         = scanning;
    scan_position_next    = scan_position;
    scan_off_next         = scan_off;
    best_seq_next         = best_seq;
    best_size_ok_next     = best_size_ok;
    best_counters_ok_next = best_counters_ok;
    best_hot_next         = best_hot;
    best_cold_next        = best_cold;
    current_page_next     = current_page;
    cur_off_next          = cur_off;
    current_seq_next      = current_seq;
    job                   = '0;
    job.kind              = JOB_STATUS;
    job.outcome           = OUT_IGNORED;
    take                  = 1'b0;
    finish                = 1'b0;
    adopt_pos             = '0;
    adopt_page            = '0;
    page_ext              = '0;
    seq_ext               = '0;

    if (item.action == ACT_BEGIN) begin
      scanning_next      = 1'b1;
      scan_position_next = '0;
      scan_off_next      = '0;
      job.outcome        = OUT_CONTINUE;
    end else if (item.action == ACT_HEADER && scanning) begin
      if (scan_position == '0) begin
        take = item.header_valid;
      end else begin
        take = item.header_valid && (rseq == best_seq + 1'b1);
      end
      finish = take ? (pos_inc >= END_POS) : (scan_position != '0);

      if (take) begin
        best_seq_next         = rseq;
        best_size_ok_next     = item.size_matches;
        best_counters_ok_next = item.counters_valid;
        best_hot_next         = item.hot_total;
        best_cold_next        = item.cold_total;
        scan_position_next    = pos_inc;
        scan_off_next         = off_inc;
      end

      if (!take && !finish) begin
        // blank first page
        job.kind          = JOB_REINIT;
        job.outcome       = OUT_REINIT_ZERO;
        scanning_next     = 1'b0;
        current_page_next = '0;
        cur_off_next      = '0;
        current_seq_next  = '0;
      end else if (!finish) begin
        job.outcome = OUT_CONTINUE;
      end else if (best_size_ok_next) begin
        adopt_pos         = scan_position_next - 1'b1;
        adopt_page        = adopt_pos[PW-1:0];
        page_ext          = {6'd0, adopt_page};
        seq_ext           = {8'd0, best_seq_next};
        job.outcome       = OUT_ADOPTED;
        job.page          = page_ext[5:0];
        job.seq           = seq_ext[7:0];
        scanning_next     = 1'b0;
        current_page_next = adopt_page;
        cur_off_next      = (scan_off_next == '0) ? LAST_OFF : scan_off_next - 1'b1;
        current_seq_next  = best_seq_next;
      end else begin
        job.kind          = JOB_REINIT;
        scanning_next     = 1'b0;
        current_page_next = '0;
        cur_off_next      = '0;
        current_seq_next  = '0;
        if (best_counters_ok_next) begin
          job.outcome = OUT_REINIT_KEPT;
          job.hot     = best_hot_next;
          job.cold    = best_cold_next;
        end else begin
          job.outcome = OUT_REINIT_ZERO;
        end
      end
    end else if (item.action == ACT_WRITE && !scanning) begin
      current_page_next = wr_page;
      cur_off_next      = wr_off;
      current_seq_next  = current_seq + 1'b1;
      page_ext          = {6'd0, wr_page};
      seq_ext           = {8'd0, current_seq_next};
      job.kind          = (wr_off == '0) ? JOB_WRITE_ERASE : JOB_WRITE;
      job.outcome       = OUT_WRITTEN;
      job.page          = page_ext[5:0];
      job.seq           = seq_ext[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning         <= 1'b0;
      scan_position    <= '0;
      scan_off         <= '0;
      best_seq         <= '0;
      best_size_ok     <= 1'b0;
      best_counters_ok <= 1'b0;
      best_hot         <= '0;
      best_cold        <= '0;
      current_page     <= '0;
      cur_off          <= '0;
      current_seq      <= '0;
    end else if (q_push) begin
      scanning         <= scanning_next;
      scan_position    <= scan_position_next;
      scan_off         <= scan_off_next;
      best_seq         <= best_seq_next;
      best_size_ok     <= best_size_ok_next;
      best_counters_ok <= best_counters_ok_next;
      best_hot         <= best_hot_next;
      best_cold        <= best_cold_next;
      current_page     <= current_page_next;
      cur_off          <= cur_off_next;
      current_seq      <= current_seq_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/frm_queue.sv
`default_nettype none
module frm_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire frm_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output frm_pkg::job_t      head_job
);
  import frm_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

  job_t          slots [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/frm_back.sv
`default_nettype none
`include "assert_macros.svh"
module frm_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire frm_pkg::job_t q_job,
  output logic               q_pop,
  output logic               result_valid,
  input  wire logic          result_ready,
  output frm_pkg::result_t   result
);
  import frm_pkg::*;

  job_t       job;
  logic       busy;
  logic [1:0] step;
  logic [1:0] last_step;
  logic       advance;
  logic       emit;
  logic       fin;
  logic       load;
  result_t    res_next;

  always_comb begin
    unique case (job.kind)
      JOB_STATUS:      last_step = 2'd0;
      JOB_REINIT:      last_step = 2'd2;
      JOB_WRITE:       last_step = 2'd0;
      JOB_WRITE_ERASE: last_step = 2'd1;
    endcase
  end

  assign advance = !result_valid || result_ready;
  assign emit    = advance && busy;
  assign fin     = emit && (step == last_step);
  assign load    = q_valid && (!busy || fin);
  assign q_pop   = load;

  always_comb begin
    res_next         = '0;
    res_next.outcome = job.outcome;
    unique case (job.kind)
      JOB_STATUS: begin
        res_next.command    = CMD_STATUS;
        res_next.page_index = job.page;
        res_next.seq_out    = job.seq;
        res_next.last       = 1'b1;
      end
      JOB_REINIT: begin
        case (step)
          2'd0: res_next.command = CMD_ERASE_REGION;
          2'd1: res_next.command = CMD_ERASE_SECTOR;
          default: begin
            res_next.command  = CMD_WRITE_PAGE;
            res_next.hot_out  = job.hot;
            res_next.cold_out = job.cold;
            res_next.last     = 1'b1;
          end
        endcase
      end
      JOB_WRITE: begin
        res_next.command    = CMD_WRITE_PAGE;
        res_next.page_index = job.page;
        res_next.seq_out    = job.seq;
        res_next.last       = 1'b1;
      end
      JOB_WRITE_ERASE: begin
        res_next.page_index = job.page;
        if (step == 2'd0) begin
          res_next.command = CMD_ERASE_SECTOR;
        end else begin
          res_next.command = CMD_WRITE_PAGE;
          res_next.seq_out = job.seq;
          res_next.last    = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job <= q_job;
    end
    if (emit) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        result_valid <= busy;
      end
      if (load) begin
        busy <= 1'b1;
        step <= '0;
      end else if (fin) begin
        busy <= 1'b0;
      end else if (emit) begin
        step <= step + 1'b1;
      end
    end
  end

  `ASSERT_IMPLY(a_region_not_last, clk, rst, result_valid && result.command == CMD_ERASE_REGION, !result.last, "erase region marked last")
  `ASSERT_IMPLY(a_status_last, clk, rst, result_valid && result.command == CMD_STATUS, result.last, "status result not last")
  `ASSERT_IMPLY(a_counts_on_write, clk, rst, result_valid && (result.hot_out != '0 || result.cold_out != '0), result.command == CMD_WRITE_PAGE, "counts on non-write result")
  `ASSERT_NEVER(a_step_range, clk, rst, busy && step > last_step, "step past end of job")

endmodule
`default_nettype wire

### hw/rtl/flash_record_ring_manager.sv
`default_nettype none
// Flash record ring manager. The front end takes one request per cycle whenever the
// two-entry job queue has room, follows the boot scan of page headers and keeps the
// current page and sequence; the back end turns each queued job into its commands,
// one result per cycle while result_ready does not stall it. A request yields one
// to three results (status, write, erase sector plus write, or the three-command
// re-initialisation), all emitted before the next job is taken. A request passes the
// queue slot, job register and result register before its first result; page_index
// carries the low 6 bits of the page and seq_out the low 8 bits of the sequence.
module flash_record_ring_manager #(
  parameter int NUM_PAGES        = 64,
  parameter int PAGES_PER_SECTOR = 16,
  parameter int SEQ_BITS         = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire frm_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output frm_pkg::result_t      result
);
  import frm_pkg::*;

  logic q_full;
  logic q_push;
  job_t q_push_job;
  logic q_pop;
  logic q_valid;
  job_t q_head;

  frm_front #(
    .NUM_PAGES        (NUM_PAGES),
    .PAGES_PER_SECTOR (PAGES_PER_SECTOR),
    .SEQ_BITS         (SEQ_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_push_job)
  );

  frm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head)
  );

  frm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_job        (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire

### verif/tb_flash_record_ring_manager.sv
`timescale 1ns / 1ps
module tb_flash_record_ring_manager;
  import frm_pkg::*;

  localparam int NUM_PAGES = 64;
  localparam int PAGES_PER_SECTOR = 16;
  localparam int SEQ_BITS = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  class ring_tracker;
    result_t expected_cmds[$];
    bit scanning;
    bit [6:0] scan_pos;
    bit [7:0] best_seq;
    bit best_size_ok;
    bit best_cnt_ok;
    bit [31:0] best_hot;
    bit [31:0] best_cold;
    bit [5:0] cur_page;
    bit [7:0] cur_seq;
    int mismatches;
    int requests;
    int results;
    int adopted;
    int reinits;
    int kept;
    int page_writes;
    int sector_erases;
    int ignored;

    function int pending();
      return expected_cmds.size();
    endfunction

    function string fmt(result_t r);
      return $sformatf("cmd=%0d outcome=%0d page=%0d seq=%0d hot=%h cold=%h last=%0b",
                       r.command, r.outcome, r.page_index, r.seq_out, r.hot_out, r.cold_out,
                       r.last);
    endfunction

    function void push(logic [1:0] cmd, logic [2:0] outc, logic [5:0] page, logic [7:0] seq,
                       logic [31:0] hot, logic [31:0] cold);
      result_t r;
      r.command = cmd;
      r.outcome = outc;
      r.page_index = page;
      r.seq_out = seq;
      r.hot_out = hot;
      r.cold_out = cold;
      r.last = 1'b0;
      expected_cmds.push_back(r);
      if (outc == OUT_ADOPTED) adopted++;
      if (outc == OUT_IGNORED) ignored++;
      if (cmd == CMD_ERASE_REGION) reinits++;
      if (cmd == CMD_ERASE_REGION && outc == OUT_REINIT_KEPT) kept++;
      if (cmd == CMD_ERASE_SECTOR && outc == OUT_WRITTEN) sector_erases++;
      if (cmd == CMD_WRITE_PAGE && outc == OUT_WRITTEN) page_writes++;
    endfunction

    function void reinit(logic [2:0] outc, logic [31:0] hot, logic [31:0] cold);
      push(CMD_ERASE_REGION, outc, 6'd0, 8'd0, 32'd0, 32'd0);
      push(CMD_ERASE_SECTOR, outc, 6'd0, 8'd0, 32'd0, 32'd0);
      push(CMD_WRITE_PAGE, outc, 6'd0, 8'd0, hot, cold);
      cur_page = 6'd0;
      cur_seq = 8'd0;
      scanning = 1'b0;
    endfunction

    function void finish_chain();
      bit [5:0] page;
      page = 6'(scan_pos - 7'd1);
      if (best_size_ok) begin
        cur_page = page;
        cur_seq = best_seq;
        scanning = 1'b0;
        push(CMD_STATUS, OUT_ADOPTED, page, best_seq, 32'd0, 32'd0);
      end else if (best_cnt_ok) begin
        reinit(OUT_REINIT_KEPT, best_hot, best_cold);
      end else begin
        reinit(OUT_REINIT_ZERO, 32'd0, 32'd0);
      end
    endfunction

    function void take_header(item_t it);
      best_seq = it.record_seq;
      best_size_ok = it.size_matches;
      best_cnt_ok = it.counters_valid;
      best_hot = it.hot_total;
      best_cold = it.cold_total;
      scan_pos++;
      if (scan_pos >= NUM_PAGES) finish_chain();
      else push(CMD_STATUS, OUT_CONTINUE, 6'd0, 8'd0, 32'd0, 32'd0);
    endfunction

    function void note_request(item_t it);
      bit [7:0] next_seq;
      int pg;
      requests++;
      next_seq = best_seq + 8'd1;
      case (it.action)
        ACT_BEGIN: begin
          scanning = 1'b1;
          scan_pos = 7'd0;
          push(CMD_STATUS, OUT_CONTINUE, 6'd0, 8'd0, 32'd0, 32'd0);
        end
        ACT_HEADER: begin
          if (!scanning) begin
            push(CMD_STATUS, OUT_IGNORED, 6'd0, 8'd0, 32'd0, 32'd0);
          end else if (scan_pos == 0 && !it.header_valid) begin
            reinit(OUT_REINIT_ZERO, 32'd0, 32'd0);
          end else if (scan_pos == 0 || (it.header_valid && it.record_seq == next_seq)) begin
            take_header(it);
          end else begin
            finish_chain();
          end
        end
        ACT_WRITE: begin
          if (scanning) begin
            push(CMD_STATUS, OUT_IGNORED, 6'd0, 8'd0, 32'd0, 32'd0);
          end else begin
            pg = int'(cur_page) + 1;
            if (pg >= NUM_PAGES) pg = 0;
            cur_page = 6'(pg);
            cur_seq = cur_seq + 8'd1;
            if (pg % PAGES_PER_SECTOR == 0)
              push(CMD_ERASE_SECTOR, OUT_WRITTEN, cur_page, 8'd0, 32'd0, 32'd0);
            push(CMD_WRITE_PAGE, OUT_WRITTEN, cur_page, cur_seq, 32'd0, 32'd0);
          end
        end
        default: begin
          push(CMD_STATUS, OUT_IGNORED, 6'd0, 8'd0, 32'd0, 32'd0);
        end
      endcase
      expected_cmds[expected_cmds.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 50) $display("MISMATCH: %s", msg);
    endtask

    task check_result(result_t got);
      result_t exp_r;
      results++;
      if (expected_cmds.size() == 0) begin
        report($sformatf("result %0d with nothing pending: %s", results, fmt(got)));
      end else begin
        exp_r = expected_cmds.pop_front();
        if (got !== exp_r)
          report($sformatf("result %0d: got %s, wanted %s", results, fmt(got), fmt(exp_r)));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  item_t item = '0;
  logic result_ready = 1'b0;
  logic item_ready;
  logic result_valid;
  result_t result;

  ring_tracker tracker;
  int send_idle;
  int recv_idle;
  int sent;
  int cycles;

  flash_record_ring_manager #(
    .NUM_PAGES(NUM_PAGES),
    .PAGES_PER_SECTOR(PAGES_PER_SECTOR),
    .SEQ_BITS(SEQ_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("flash_record_ring_manager verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) tracker.check_result(result);
      result_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic item_t make_req(logic [1:0] act, bit hv, logic [7:0] seq, bit sz, bit cv);
    item_t it;
    it.action = act;
    it.header_valid = hv;
    it.record_seq = seq;
    it.size_matches = sz;
    it.counters_valid = cv;
    it.hot_total = $urandom;
    it.cold_total = $urandom;
    return it;
  endfunction

  task automatic send_req(input item_t it);
    if ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    tracker.note_request(it);
    sent++;
  endtask

  task automatic header(bit hv, logic [7:0] seq, bit sz, bit cv);
    send_req(make_req(ACT_HEADER, hv, seq, sz, cv));
  endtask

  task automatic begin_scan();
    send_req(make_req(ACT_BEGIN, 1'($urandom_range(1)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), 1'($urandom_range(1))));
  endtask

  task automatic write_req();
    send_req(make_req(ACT_WRITE, 1'($urandom_range(1)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), 1'($urandom_range(1))));
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // scan of len chained pages, broken afterwards unless it fills the region, then writes
  task automatic scan_session(int len, logic [7:0] start_seq);
    int n_writes;
    begin_scan();
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 4) write_req();
      header(1'b1, start_seq + 8'(i), $urandom_range(9) != 0, 1'($urandom_range(1)));
    end
    if (len < NUM_PAGES) begin
      if ($urandom_range(1))
        header(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      else
        header(1'b1, start_seq + 8'(len) + 8'd1 + 8'($urandom_range(253)),
               1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    n_writes = $urandom_range(8);
    repeat (n_writes) write_req();
  endtask

  task automatic random_phase(int budget);
    int stop;
    int r;
    stop = sent + budget;
    while (sent < stop) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_req(make_req(2'($urandom_range(3)), 1'($urandom_range(1)),
                          8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1))));
      end else if (r < 14) begin
        begin_scan();
        header(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        scan_session(($urandom_range(9) == 0) ? $urandom_range(40, NUM_PAGES)
                                              : $urandom_range(1, 10),
                     8'($urandom_range(255)));
      end
    end
  endtask

  task automatic directed();
    item_t it;
    write_req();
    header(1'b1, 8'd3, 1'b1, 1'b1);
    it = '1;
    it.action = ACT_UNUSED;
    send_req(it);
    // blank first page
    begin_scan();
    header(1'b0, 8'd0, 1'b1, 1'b1);
    // chain across the sequence wrap, then adopted
    begin_scan();
    it = make_req(ACT_HEADER, 1'b1, 8'd255, 1'b1, 1'b1);
    it.hot_total = '1;
    it.cold_total = '1;
    send_req(it);
    header(1'b1, 8'd0, 1'b1, 1'b0);
    header(1'b0, 8'd1, 1'b1, 1'b1);
    write_req();
    // stale size with counters kept
    begin_scan();
    write_req();
    it = make_req(ACT_HEADER, 1'b1, 8'd7, 1'b0, 1'b1);
    it.hot_total = '1;
    send_req(it);
    header(1'b1, 8'd9, 1'b1, 1'b1);
    // stale size, counters zeroed
    begin_scan();
    it = make_req(ACT_HEADER, 1'b1, 8'd42, 1'b0, 1'b0);
    it.hot_total = '0;
    it.cold_total = '0;
    send_req(it);
    header(1'b0, 8'd43, 1'b1, 1'b1);
    // restart in the middle of a scan
    begin_scan();
    header(1'b1, 8'd5, 1'b1, 1'b1);
    begin_scan();
    header(1'b1, 8'd100, 1'b1, 1'b0);
    header(1'b1, 8'd101, 1'b1, 1'b0);
    header(1'b1, 8'd100, 1'b1, 1'b1);
  endtask

  initial begin
    tracker = new();
    send_idle = 37;
    recv_idle = 56;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    directed();
    // full region chain; if the last page's size matches it is adopted there and writes wrap to page 0
    scan_session(NUM_PAGES, 8'd250);
    write_req();
    write_req();
    random_phase(35);
    wait_idle();
    send_idle = 56;
    recv_idle = 37;
    random_phase(35);
    wait_idle();
    send_idle = 0;
    recv_idle = 0;
    random_phase(35);
    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d requests and %0d results: %0d adopted scans, %0d ignored requests",
             tracker.requests, tracker.results, tracker.adopted, tracker.ignored);
    $display("%0d reinitializations (%0d kept counters), %0d page writes, %0d sector erases",
             tracker.reinits, tracker.kept, tracker.page_writes, tracker.sector_erases);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("flash_record_ring_manager verification clean");
    end else begin
      $display("flash_record_ring_manager verification failed");
    end
    $finish;
  end

endmodule
